/* src/minicomputer_double_to_ieee_double_macros.svh */
// Assertion macros used by the checker file of the float conversion block.
`ifndef MINICOMPUTER_DOUBLE_TO_IEEE_DOUBLE_MACROS_SVH
`define MINICOMPUTER_DOUBLE_TO_IEEE_DOUBLE_MACROS_SVH

// Consequent must hold in the cycle after the antecedent, outside reset.
`define MD2ID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent, outside reset.
`define MD2ID_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle check that stays active during reset.
`define MD2ID_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* src/md2id_pkg.sv */
// Types, constants and helper functions of the minicomputer to IEEE double converter.
package md2id_pkg;

  // Source exponent bias and IEEE double bias.
  localparam logic [15:0]        SRC_BIAS  = 16'h0080;
  localparam logic signed [16:0] DST_BIAS  = 17'sd1023;
  // Target exponents below this flush to zero.
  localparam logic signed [16:0] EXP_TINY  = -17'sd50;
  // Largest finite biased exponent.
  localparam logic signed [16:0] EXP_LIMIT = 17'sd2046;

  // Saturated result, sign excluded.
  localparam logic [30:0] SAT_HIGH = 31'h7fefffff;
  localparam logic [31:0] SAT_LOW  = 32'hffffffff;

  // Result classes carried down the pipeline.
  localparam logic [1:0] KIND_ZERO   = 2'd0;
  localparam logic [1:0] KIND_DENORM = 2'd1;
  localparam logic [1:0] KIND_NORMAL = 2'd2;
  localparam logic [1:0] KIND_SAT    = 2'd3;

  // Input transaction.
  typedef struct packed {
    logic [31:0] src_high;
    logic [31:0] src_low;
  } in_t;

  // Output transaction.
  typedef struct packed {
    logic [31:0] ieee_high;
    logic [31:0] ieee_low;
  } out_t;

  // Stage 1: unpacked fields.
  typedef struct packed {
    logic               sign;
    logic               zero;
    logic [47:0]        m48;
    logic signed [16:0] ex;
  } st1_t;

  // Stage 2: magnitude aligned to the hidden bit, coarse class.
  typedef struct packed {
    logic               sign;
    logic [1:0]         kind;
    logic [52:0]        v;
    logic signed [16:0] ex;
  } st2_t;

  // Stage 3: leading zero count added.
  typedef struct packed {
    logic               sign;
    logic [1:0]         kind;
    logic [52:0]        v;
    logic signed [16:0] ex;
    logic [5:0]         lz;
  } st3_t;

  // Stage 4: control handed to the alignment and packing logic.
  typedef struct packed {
    logic        sign;
    logic [1:0]  kind;
    logic [52:0] v;
    logic [5:0]  shamt;
    logic        post_shr;
    logic [10:0] exp_out;
  } st4_t;

  // Leading zero count of the 53-bit magnitude; the highest set bit wins last.
  function automatic logic [5:0] lead_zeros(input logic [52:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (v[i]) begin
        n = 6'(52 - i);
      end
    end
    return n;
  endfunction

endpackage

/* src/md2id_align.sv */
// Final shift, rounding and packing of the IEEE double result.
module md2id_align
  import md2id_pkg::*;
(
  input  st4_t ctrl,
  output out_t res
);

  logic [52:0] rsh;
  logic [52:0] rnd;
  logic [52:0] lsh;
  logic [52:0] nrm;

  // Denormal path: logical right shift, then round half up.
  assign rsh = ctrl.v >> ctrl.shamt;
  assign rnd = (rsh + 53'd1) >> 1;

  // Normal path: normalize, then one more right shift at exponent zero.
  assign lsh = ctrl.v << ctrl.shamt;
  assign nrm = ctrl.post_shr ? (lsh >> 1) : lsh;

  // Pick the result by class.
  always_comb begin
    case (ctrl.kind)
      KIND_ZERO: begin
        res.ieee_high = 32'd0;
        res.ieee_low  = 32'd0;
      end
      KIND_DENORM: begin
        res.ieee_high = {ctrl.sign, 11'd0, rnd[51:32]};
        res.ieee_low  = rnd[31:0];
      end
      KIND_NORMAL: begin
        res.ieee_high = {ctrl.sign, ctrl.exp_out, nrm[51:32]};
        res.ieee_low  = nrm[31:0];
      end
      default: begin
        res.ieee_high = {ctrl.sign, SAT_HIGH};
        res.ieee_low  = SAT_LOW;
      end
    endcase
  end

endmodule

/* src/minicomputer_double_to_ieee_double.sv */
// Top level of the minicomputer double to IEEE 754 double converter.
//
// Usage: one input transaction carries a 64-bit minicomputer double
// (src_high, src_low); one output transaction carries the IEEE double
// (ieee_high, ieee_low). Both channels use valid and stall; a transaction
// moves on a rising edge with valid high and stall low.
// Path: an accepted input moves through the registers st1, st2, st3, st4
// and out_data, in that order, before the result can be taken.
// Throughput: one conversion per cycle when not stalled. The five
// register stages are unpack, negate, leading zero count, shift select,
// and shift/round/pack into the output register; each is one narrow step deep.
// Each stage holds while the stage after it is full and held, so a stall
// on the output ripples back to in_stall without losing or repeating
// anything; empty stages keep accepting until the pipeline is full.
// Reset (rst, synchronous) clears all valid bits; the datapath registers
// are not reset.
module minicomputer_double_to_ieee_double
  import md2id_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  st1_t st1;
  st2_t st2;
  st3_t st3;
  st4_t st4;
  st1_t st1_next;
  st2_t st2_next;
  st3_t st3_next;
  st4_t st4_next;
  out_t res;
  logic valid1;
  logic valid2;
  logic valid3;
  logic valid4;
  logic en1;
  logic en2;
  logic en3;
  logic en4;
  logic en5;
  logic [15:0] e16;
  logic [47:0] mag;
  logic [5:0]  lshamt;
  logic signed [16:0] exn;

  // Per-stage load enables: a stage loads when empty or when its successor moves.
  assign en5 = !out_valid || !out_stall;
  assign en4 = !valid4 || en5;
  assign en3 = !valid3 || en4;
  assign en2 = !valid2 || en3;
  assign en1 = !valid1 || en2;
  assign in_stall = !en1;

  // Stage 1: split mantissa and rebias the exponent.
  always_comb begin
    e16           = in_data.src_low[15:0] - SRC_BIAS;
    st1_next.sign = in_data.src_high[31];
    st1_next.m48  = {in_data.src_high, in_data.src_low[31:16]};
    st1_next.zero = (st1_next.m48 == 48'd0);
    st1_next.ex   = $signed({e16[15], e16}) + DST_BIAS;
  end

  // Stage 2: magnitude and coarse classification.
  always_comb begin
    mag           = st1.sign ? (48'd0 - st1.m48) : st1.m48;
    st2_next.sign = st1.sign;
    st2_next.v    = {mag, 5'd0};
    st2_next.ex   = st1.ex;
    if (st1.zero || (st1.ex < EXP_TINY)) begin
      st2_next.kind = KIND_ZERO;
    end else if (st1.ex < 17'sd0) begin
      st2_next.kind = KIND_DENORM;
    end else begin
      st2_next.kind = KIND_NORMAL;
    end
  end

  // Stage 3: leading zero search.
  always_comb begin
    st3_next.sign = st2.sign;
    st3_next.kind = st2.kind;
    st3_next.v    = st2.v;
    st3_next.ex   = st2.ex;
    st3_next.lz   = lead_zeros(st2.v);
  end

  // Stage 4: shift amount, final exponent and saturation.
  always_comb begin
    lshamt = ($signed({11'd0, st3.lz}) < st3.ex) ? st3.lz : st3.ex[5:0];
    exn    = st3.ex - $signed({11'd0, lshamt});
    st4_next.sign     = st3.sign;
    st4_next.v        = st3.v;
    st4_next.kind     = st3.kind;
    st4_next.shamt    = lshamt;
    st4_next.post_shr = (exn == 17'sd0);
    st4_next.exp_out  = exn[10:0];
    if (st3.kind == KIND_DENORM) begin
      st4_next.shamt    = 6'(17'sd0 - st3.ex);
      st4_next.post_shr = 1'b0;
      st4_next.exp_out  = 11'd0;
    end else if ((st3.kind == KIND_NORMAL) && (exn > EXP_LIMIT)) begin
      st4_next.kind = KIND_SAT;
    end
  end

  // Stage 5: shift, round and pack.
  md2id_align u_align (
    .ctrl (st4),
    .res  (res)
  );

  // Valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      valid3    <= 1'b0;
      valid4    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en1) valid1    <= in_valid;
      if (en2) valid2    <= valid1;
      if (en3) valid3    <= valid2;
      if (en4) valid4    <= valid3;
      if (en5) out_valid <= valid4;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (en1) st1      <= st1_next;
    if (en2) st2      <= st2_next;
    if (en3) st3      <= st3_next;
    if (en4) st4      <= st4_next;
    if (en5) out_data <= res;
  end

endmodule

/* src/md2id_checker.sv */
// Port-level checker for the converter and its bind to the top level.
`include "minicomputer_double_to_ieee_double_macros.svh"

module md2id_checker
  import md2id_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  // The output register is empty right after reset.
  `MD2ID_ASSERT_NEXT_ALWAYS(a_reset_empty, clk, rst, !out_valid, "output valid after reset")

  // The converter never produces an infinity or NaN exponent.
  `MD2ID_ASSERT_SAME(a_finite, clk, rst, out_valid, out_data.ieee_high[30:20] != 11'h7ff, "non-finite result")

  // The input only stalls when a held result fills the whole pipeline.
  `MD2ID_ASSERT_SAME(a_stall_source, clk, rst, in_stall, out_valid && out_stall, "input stalled early")

  // A held result stays offered.
  `MD2ID_ASSERT_NEXT(a_hold_valid, clk, rst, out_valid && out_stall, out_valid, "valid dropped under stall")

  // A held result keeps its value.
  `MD2ID_ASSERT_NEXT(a_hold_data, clk, rst, out_valid && out_stall, $stable(out_data), "payload changed under stall")

endmodule

bind minicomputer_double_to_ieee_double md2id_checker u_md2id_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
